[rtl/core/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell, sorted_priority_queue, spq_checker and testbench.
package spq_pkg;

    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int FILL_W   = 5;

    // Action codes carried on the input word
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Per-cell control, broadcast from the top level
    typedef struct packed {
        logic enq;        // enqueue accepted and queue not full
        logic deq;        // dequeue accepted and queue not empty
        logic occupied;   // this cell holds a live entry
    } cell_op_t;

endpackage

[rtl/core/sorted_priority_queue.sv]
// Top level of the sorted priority queue: a row of spq_cell slots, the fill
// counter and the result register. Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: action, item_data,
//   item_priority. action ACT_ENQ inserts item_data behind every stored entry
//   of equal or higher priority; ACT_DEQ removes the head entry.
//   Result channel (res_valid / res_stall) returns one word per input word:
//   out_data and out_valid for a dequeue that found an entry, was_empty for a
//   dequeue on an empty queue, dropped_full for an enqueue on a full queue,
//   and fill_count, the entry count after the word (low five bits).
//   res_valid rises in the cycle after acceptance. One word is taken per
//   cycle while in_stall is low: every cell compares its priority with the new
//   word in parallel and moves its entry one place in the same cycle.
//   in_stall rises only while a result is held and res_stall is high; the
//   result register then holds its word and no input is taken.
//   Reset empties the queue (count to zero) and clears res_valid; the slot
//   contents are left as they are, since only slots below the count are read.
module sorted_priority_queue
#(
    parameter int CAPACITY = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic signed [spq_pkg::DATA_W-1:0]  item_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]  item_priority,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic signed [spq_pkg::DATA_W-1:0]  out_data,
    output logic                               out_valid,
    output logic                               was_empty,
    output logic                               dropped_full,
    output logic [spq_pkg::FILL_W-1:0]         fill_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             res_valid_reg;
    logic signed [spq_pkg::DATA_W-1:0] out_data_reg;
    logic signed [spq_pkg::DATA_W-1:0] out_data_next;
    logic             out_valid_reg;
    logic             was_empty_reg;
    logic             dropped_full_reg;
    logic [spq_pkg::FILL_W-1:0] fill_count_reg;

    logic in_accept;
    logic is_full;
    logic is_empty;
    logic do_enq;
    logic do_deq;

    logic                              cell_ge   [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] cell_prio [CAPACITY];

    // Take a word whenever the result register is free or being drained
    assign in_stall  = res_valid_reg && res_stall;
    assign in_accept = in_valid && !in_stall;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign do_enq   = in_accept && (action == spq_pkg::ACT_ENQ) && !is_full;
    assign do_deq   = in_accept && (action == spq_pkg::ACT_DEQ) && !is_empty;

    // Build the row of cells; ends see fixed neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::cell_op_t                 op;
        logic                              prev_ge;
        logic signed [spq_pkg::DATA_W-1:0] prev_data;
        logic signed [spq_pkg::PRIO_W-1:0] prev_prio;
        logic signed [spq_pkg::DATA_W-1:0] next_data;
        logic signed [spq_pkg::PRIO_W-1:0] next_prio;

        assign op.enq      = do_enq;
        assign op.deq      = do_deq;
        assign op.occupied = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign prev_ge   = 1'b1;
            assign prev_data = item_data;
            assign prev_prio = item_priority;
        end
        else
        begin : g_body
            assign prev_ge   = cell_ge[i-1];
            assign prev_data = cell_data[i-1];
            assign prev_prio = cell_prio[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_data = cell_data[i];
            assign next_prio = cell_prio[i];
        end
        else
        begin : g_inner
            assign next_data = cell_data[i+1];
            assign next_prio = cell_prio[i+1];
        end

        spq_cell u_cell
        (
            .clk       (clk),
            .op        (op),
            .new_data  (item_data),
            .new_prio  (item_priority),
            .prev_ge   (prev_ge),
            .prev_data (prev_data),
            .prev_prio (prev_prio),
            .next_data (next_data),
            .next_prio (next_prio),
            .ge        (cell_ge[i]),
            .data      (cell_data[i]),
            .prio      (cell_prio[i])
        );
    end

    // Advance the entry count
    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign out_data_next = do_deq ? cell_data[0] : '0;

    // Count and result status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            res_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            was_empty_reg    <= 1'b0;
            dropped_full_reg <= 1'b0;
            fill_count_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_accept)
            begin
                res_valid_reg    <= 1'b1;
                out_valid_reg    <= do_deq;
                was_empty_reg    <= (action == spq_pkg::ACT_DEQ) && is_empty;
                dropped_full_reg <= (action == spq_pkg::ACT_ENQ) && is_full;
                fill_count_reg   <= spq_pkg::FILL_W'(count_next);
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result data word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_data     = out_data_reg;
    assign out_valid    = out_valid_reg;
    assign was_empty    = was_empty_reg;
    assign dropped_full = dropped_full_reg;
    assign fill_count   = fill_count_reg;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(out_valid && was_empty) && !(out_valid && dropped_full))
        else $error("conflicting result flags");

    a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (action == spq_pkg::ACT_ENQ) && is_full
        |=> res_valid && dropped_full && (count_reg == $past(count_reg)))
        else $error("enqueue on full queue not dropped");

    a_deq_count : assert property (@(posedge clk) disable iff (!rst_n)
        do_deq |=> out_valid && (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not remove one entry");
`endif

endmodule

[rtl/core/spq_cell.sv]
// One slot of the sorted queue: holds a data word and its priority.
// Depends on spq_pkg for widths and the cell control struct.
module spq_cell
(
    input  logic                                 clk,
    input  spq_pkg::cell_op_t                    op,
    input  logic signed [spq_pkg::DATA_W-1:0]    new_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]    new_prio,
    input  logic                                 prev_ge,
    input  logic signed [spq_pkg::DATA_W-1:0]    prev_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]    prev_prio,
    input  logic signed [spq_pkg::DATA_W-1:0]    next_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]    next_prio,
    output logic                                 ge,
    output logic signed [spq_pkg::DATA_W-1:0]    data,
    output logic signed [spq_pkg::PRIO_W-1:0]    prio
);

    logic signed [spq_pkg::DATA_W-1:0] data_reg;
    logic signed [spq_pkg::DATA_W-1:0] data_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;

    // Entry stays ahead of the new word when its priority is at least as high
    assign ge = op.occupied && (prio_reg >= new_prio);

    // Hold, take the new word, shift down from the previous cell, or pull up
    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (op.enq && !ge)
        begin
            if (prev_ge)
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
            else
            begin
                data_next = prev_data;
                prio_next = prev_prio;
            end
        end
        else if (op.deq)
        begin
            data_next = next_data;
            prio_next = next_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

[dv/spq_checker.sv]
// Checker for the sorted priority queue: watches the input and result channels,
// keeps its own sorted copy of the queue and compares every result word.
// Depends on spq_pkg for the action codes and field widths.
module spq_checker
#(
    parameter int CAPACITY = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                action,
    input  logic signed [spq_pkg::DATA_W-1:0]   item_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  logic signed [spq_pkg::DATA_W-1:0]   out_data,
    input  logic                                out_valid,
    input  logic                                was_empty,
    input  logic                                dropped_full,
    input  logic [spq_pkg::FILL_W-1:0]          fill_count,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  words_checked,
    output int                                  empty_hits,
    output int                                  full_drops
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [spq_pkg::DATA_W-1:0] data;
        logic                              valid;
        logic                              empty;
        logic                              dropped;
        logic [spq_pkg::FILL_W-1:0]        fill;
    } outcome_t;

    // Sorted copy of the queue, head at slot 0
    logic signed [spq_pkg::DATA_W-1:0] slot_data_m [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] slot_prio_m [CAPACITY];
    int                                held = 0;
    outcome_t                          outcomes_due [$];

    // Apply one input word to the sorted copy and return the word it owes
    function automatic outcome_t take_word(logic act,
                                           logic signed [spq_pkg::DATA_W-1:0] d,
                                           logic signed [spq_pkg::PRIO_W-1:0] p);
        outcome_t o;
        int       pos;
        int       k;
        o = '0;
        if (act == spq_pkg::ACT_ENQ)
        begin
            if (held >= CAPACITY)
            begin
                o.dropped = 1'b1;
            end
            else
            begin
                // Insert behind every entry of equal or higher priority
                pos = 0;
                while (pos < held && slot_prio_m[pos] >= p)
                    pos++;
                for (k = held; k > pos; k--)
                begin
                    slot_data_m[k] = slot_data_m[k-1];
                    slot_prio_m[k] = slot_prio_m[k-1];
                end
                slot_data_m[pos] = d;
                slot_prio_m[pos] = p;
                held++;
            end
        end
        else
        begin
            if (held == 0)
            begin
                o.empty = 1'b1;
            end
            else
            begin
                // Pop the head and shift the rest up
                o.data  = slot_data_m[0];
                o.valid = 1'b1;
                for (k = 0; k < held - 1; k++)
                begin
                    slot_data_m[k] = slot_data_m[k+1];
                    slot_prio_m[k] = slot_prio_m[k+1];
                end
                held--;
            end
        end
        o.fill = spq_pkg::FILL_W'(held);
        return o;
    endfunction

    // Report one field mismatch; returns 1 when the field differs
    function automatic int field_bad(string name, logic [spq_pkg::DATA_W-1:0] want,
                                     logic [spq_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Compare the finished word first, then book the newly accepted one
    always @(posedge clk)
    begin
        outcome_t owed;
        int       bad;
        bad = 0;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("result word with nothing owed: out_data 'h%0h fill_count %0d",
                           out_data, fill_count);
                    bad++;
                end
                else
                begin
                    owed = outcomes_due.pop_front();
                    bad += field_bad("out_data", owed.data, out_data);
                    bad += field_bad("out_valid", spq_pkg::DATA_W'(owed.valid),
                                     spq_pkg::DATA_W'(out_valid));
                    bad += field_bad("was_empty", spq_pkg::DATA_W'(owed.empty),
                                     spq_pkg::DATA_W'(was_empty));
                    bad += field_bad("dropped_full", spq_pkg::DATA_W'(owed.dropped),
                                     spq_pkg::DATA_W'(dropped_full));
                    bad += field_bad("fill_count", spq_pkg::DATA_W'(owed.fill),
                                     spq_pkg::DATA_W'(fill_count));
                    words_checked <= words_checked + 1;
                    empty_hits    <= empty_hits + int'(owed.empty);
                    full_drops    <= full_drops + int'(owed.dropped);
                end
            end
            if (in_valid && !in_stall)
                outcomes_due.push_back(take_word(action, item_data, item_priority));
        end
        fail_count <= fail_count + bad;
        pending    <= outcomes_due.size();
    end

endmodule

[dv/testbench.sv]
// Top of the sorted priority queue testbench: clock, reset, stimulus, result
// stall and verdict. Depends on spq_pkg, sorted_priority_queue and spq_checker.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;

    logic                               clk;
    logic                               rst_n         = 1'b0;
    logic                               in_valid      = 1'b0;
    logic                               in_stall;
    logic                               action        = spq_pkg::ACT_ENQ;
    logic signed [spq_pkg::DATA_W-1:0]  item_data     = '0;
    logic signed [spq_pkg::PRIO_W-1:0]  item_priority = '0;
    logic                               res_valid;
    logic                               res_stall     = 1'b0;
    logic signed [spq_pkg::DATA_W-1:0]  out_data;
    logic                               out_valid;
    logic                               was_empty;
    logic                               dropped_full;
    logic [spq_pkg::FILL_W-1:0]         fill_count;

    int fail_count;
    int pending;
    int words_checked;
    int empty_hits;
    int full_drops;
    int cycles = 0;

    bit quiet    = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;   // ask the result side for a long stall

    sorted_priority_queue #(.CAPACITY(CAPACITY)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .item_data     (item_data),
        .item_priority (item_priority),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_data      (out_data),
        .out_valid     (out_valid),
        .was_empty     (was_empty),
        .dropped_full  (dropped_full),
        .fill_count    (fill_count)
    );

    spq_checker #(.CAPACITY(CAPACITY)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .item_data     (item_data),
        .item_priority (item_priority),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_data      (out_data),
        .out_valid     (out_valid),
        .was_empty     (was_empty),
        .dropped_full  (dropped_full),
        .fill_count    (fill_count),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .empty_hits    (empty_hits),
        .full_drops    (full_drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still owed", cycles, pending);
            $display("FAIL sorted_priority_queue");
            $finish;
        end
    end

    // Result side: random stall, or a long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                res_stall <= !quiet && ($urandom_range(99) < 19);
            end
        end
    end

    // Offer one word, idling at random first; return once it is taken
    task automatic push_word(input logic act,
                             input logic signed [spq_pkg::DATA_W-1:0] d,
                             input logic signed [spq_pkg::PRIO_W-1:0] p);
        while (!quiet && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        item_data     <= d;
        item_priority <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every owed word has come back
    task automatic drain_queue();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Priorities: many ties in a narrow band, the extremes, or anything
    function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            0: return spq_pkg::PRIO_W'($urandom_range(3));
            1: case ($urandom_range(3))
                   0: return 16'sh7FFF;
                   1: return 16'sh8000;
                   2: return 16'sh0000;
                   default: return 16'shFFFF;
               endcase
            default: return spq_pkg::PRIO_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_data();
        case ($urandom_range(7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            default: return spq_pkg::DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int i;
        int b;
        int enq_pct;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeue, extremes, ties, fill to full, one refused
        push_word(spq_pkg::ACT_DEQ, 32'sh12345678, 16'sh0042);
        push_word(spq_pkg::ACT_ENQ, 32'sh7FFFFFFF, 16'sh7FFF);
        push_word(spq_pkg::ACT_ENQ, 32'sh80000000, 16'sh8000);
        push_word(spq_pkg::ACT_ENQ, 32'sd1, 16'sd0);
        push_word(spq_pkg::ACT_ENQ, 32'sd2, 16'sd0);
        push_word(spq_pkg::ACT_ENQ, 32'sd3, 16'sd0);
        push_word(spq_pkg::ACT_ENQ, -32'sd1, -16'sd1);
        push_word(spq_pkg::ACT_ENQ, 32'sd0, 16'sh7FFF);
        for (i = 0; i < 9; i++)
            push_word(spq_pkg::ACT_ENQ, spq_pkg::DATA_W'(i * 32'h1111_1111),
                      spq_pkg::PRIO_W'(i % 3) - 16'sd1);
        push_word(spq_pkg::ACT_ENQ, 32'shDEADBEEF, 16'sh7FFF);
        for (i = 0; i < 6; i++)
            push_word(spq_pkg::ACT_DEQ, pick_data(), pick_prio());

        // Random bursts, most leaning toward filling or emptying the queue
        for (b = 0; b < 13; b++)
        begin
            case (b % 4)
                0: enq_pct = 85;
                1: enq_pct = 50;
                2: enq_pct = 15;
                default: enq_pct = 60;
            endcase
            if (b == 2 || b == 9)
                hold_req = 1'b1;
            quiet = (b == 5);
            for (i = 0; i < 50; i++)
                push_word(($urandom_range(99) < enq_pct) ? spq_pkg::ACT_ENQ
                                                         : spq_pkg::ACT_DEQ,
                          pick_data(), pick_prio());
            quiet = 1'b0;
            if (b == 7)
                drain_queue();
        end

        drain_queue();
        repeat (4) @(posedge clk);
        $display("covered %0d result words: %0d dequeues on an empty queue, %0d refused",
                 words_checked, empty_hits, full_drops);
        $display("enqueues, with two long result stalls, one idle-free burst and a drain");
        if (fail_count == 0 && pending == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule

[sorted_priority_queue.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
dv/spq_checker.sv
dv/testbench.sv
